// File: src/dfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_pkg
// shared types, codes and constants of the depth-first path finder
// ----------------------------------------------------------------------------
package dfs_pkg;

  localparam int NODE_W        = 10;
  localparam int CMD_W         = 2;
  localparam int CFG_IDX_W     = 1;
  localparam int DEF_MAX_NODES = 1024;
  localparam int DEF_MAX_EDGES = 4096;
  localparam int LEN_SAT       = 1023;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE = 1'b0,
    CFG_TARGET = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RESP,
    ST_RD_WAIT,
    ST_CLR,
    ST_SEED,
    ST_SCAN,
    ST_POP_WAIT,
    ST_EDGE,
    ST_VISIT,
    ST_TGT,
    ST_TGT_WAIT,
    ST_TRACE,
    ST_TRACE_WAIT,
    ST_WPATH,
    ST_WPATH_WAIT
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [NODE_W-1:0] edge_end_a;
    logic [NODE_W-1:0] edge_end_b;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [NODE_W-1:0] path_length;
    logic [NODE_W-1:0] path_node;
    logic              last_node;
    logic              edge_overflow;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [NODE_W-1:0]    wdata;
  } cfg_item_t;

  // controller to datapath
  typedef struct packed {
    logic clear_graph;
    logic add_edge;
    logic search_init;
    logic clr_step;
    logic seed;
    logic edge_rd;
    logic next_edge;
    logic pop;
    logic load_top;
    logic probe;
    logic push;
    logic tgt_rd;
    logic trace_init;
    logic trace_rd;
    logic trace_step;
    logic wr_init;
    logic wr_path;
    logic wr_step;
    logic rd_issue;
    logic rd_done;
    logic load_out;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic ends_ok;
    logic clr_last;
    logic scan_more;
    logic sp_one;
    logic edge_hit;
    logic can_push;
    logic pvisited;
    logic trace_end;
    logic k_one;
    logic out_busy;
  } stat_t;

endpackage

// File: src/dfs_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_chan_if
// valid/ready channel carrying one payload per transaction
// ----------------------------------------------------------------------------
interface dfs_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/dfs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_ctrl
// sequencer for command handling, search, path trace and path readout
// ----------------------------------------------------------------------------
module dfs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  dfs_pkg::cmd_e     in_cmd,
  input  dfs_pkg::stat_t    stat,
  output logic              in_ready,
  output dfs_pkg::ctrl_t    ctrl,
  output dfs_pkg::state_t   state
);

  dfs_pkg::state_t state_r, state_nxt;

  assign state = state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dfs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      dfs_pkg::ST_IDLE: begin
        in_ready = !stat.out_busy;
        if (in_valid && !stat.out_busy) begin
          unique case (in_cmd)
            dfs_pkg::CMD_CLEAR: begin
              ctrl.clear_graph = 1'b1;
            end
            dfs_pkg::CMD_ADD: begin
              ctrl.add_edge = 1'b1;
              state_nxt     = dfs_pkg::ST_RESP;
            end
            dfs_pkg::CMD_SEARCH: begin
              ctrl.search_init = 1'b1;
              state_nxt = stat.ends_ok ? dfs_pkg::ST_CLR : dfs_pkg::ST_RESP;
            end
            dfs_pkg::CMD_READ: begin
              ctrl.rd_issue = 1'b1;
              state_nxt     = dfs_pkg::ST_RD_WAIT;
            end
            default: state_nxt = dfs_pkg::ST_IDLE;
          endcase
        end
      end
      dfs_pkg::ST_RESP: begin
        ctrl.load_out = 1'b1;
        state_nxt     = dfs_pkg::ST_IDLE;
      end
      dfs_pkg::ST_RD_WAIT: begin
        ctrl.rd_done = 1'b1;
        state_nxt    = dfs_pkg::ST_RESP;
      end
      dfs_pkg::ST_CLR: begin
        ctrl.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = dfs_pkg::ST_SEED;
        end
      end
      dfs_pkg::ST_SEED: begin
        ctrl.seed = 1'b1;
        state_nxt = dfs_pkg::ST_SCAN;
      end
      dfs_pkg::ST_SCAN: begin
        if (stat.scan_more) begin
          ctrl.edge_rd = 1'b1;
          state_nxt    = dfs_pkg::ST_EDGE;
        end else begin
          ctrl.pop  = 1'b1;
          state_nxt = stat.sp_one ? dfs_pkg::ST_TGT : dfs_pkg::ST_POP_WAIT;
        end
      end
      dfs_pkg::ST_POP_WAIT: begin
        ctrl.load_top = 1'b1;
        state_nxt     = dfs_pkg::ST_SCAN;
      end
      dfs_pkg::ST_EDGE: begin
        if (stat.edge_hit) begin
          ctrl.probe = 1'b1;
          state_nxt  = dfs_pkg::ST_VISIT;
        end else begin
          ctrl.next_edge = 1'b1;
          state_nxt      = dfs_pkg::ST_SCAN;
        end
      end
      dfs_pkg::ST_VISIT: begin
        if (stat.can_push) begin
          ctrl.push = 1'b1;
        end else begin
          ctrl.next_edge = 1'b1;
        end
        state_nxt = dfs_pkg::ST_SCAN;
      end
      dfs_pkg::ST_TGT: begin
        ctrl.tgt_rd = 1'b1;
        state_nxt   = dfs_pkg::ST_TGT_WAIT;
      end
      dfs_pkg::ST_TGT_WAIT: begin
        if (stat.pvisited) begin
          ctrl.trace_init = 1'b1;
          state_nxt       = dfs_pkg::ST_TRACE;
        end else begin
          state_nxt = dfs_pkg::ST_RESP;
        end
      end
      dfs_pkg::ST_TRACE: begin
        if (stat.trace_end) begin
          ctrl.wr_init = 1'b1;
          state_nxt    = dfs_pkg::ST_WPATH;
        end else begin
          ctrl.trace_rd = 1'b1;
          state_nxt     = dfs_pkg::ST_TRACE_WAIT;
        end
      end
      dfs_pkg::ST_TRACE_WAIT: begin
        ctrl.trace_step = 1'b1;
        state_nxt       = dfs_pkg::ST_TRACE;
      end
      dfs_pkg::ST_WPATH: begin
        ctrl.wr_path = 1'b1;
        state_nxt = stat.k_one ? dfs_pkg::ST_RESP : dfs_pkg::ST_WPATH_WAIT;
      end
      dfs_pkg::ST_WPATH_WAIT: begin
        ctrl.wr_step = 1'b1;
        state_nxt    = dfs_pkg::ST_WPATH;
      end
      default: state_nxt = dfs_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: src/dfs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_dp
// edge store, parent table, stack, path buffer and their counters
// ----------------------------------------------------------------------------
module dfs_dp #(
  parameter int MAX_NODES = dfs_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = dfs_pkg::DEF_MAX_EDGES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dfs_pkg::ctrl_t                ctrl,
  input  logic [dfs_pkg::NODE_W-1:0]    in_a,
  input  logic [dfs_pkg::NODE_W-1:0]    in_b,
  input  logic                          cfg_we,
  input  dfs_pkg::cfg_item_t            cfg_item,
  input  logic                          out_ready,
  output logic                          out_valid,
  output dfs_pkg::out_item_t            out_item,
  output dfs_pkg::stat_t                stat
);

  localparam int NW  = dfs_pkg::NODE_W;
  localparam int NAW = $clog2(MAX_NODES);
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int SW  = ECW + NW;

  // memories
  logic [2*NW-1:0] edge_mem [MAX_EDGES];
  logic [NW:0]     par_mem  [MAX_NODES];
  logic [SW-1:0]   stk_mem  [MAX_NODES];
  logic [NW-1:0]   pbuf_mem [MAX_NODES];

  logic [2*NW-1:0] edata_r;
  logic [NW:0]     pdata_r;
  logic [SW-1:0]   sdata_r;
  logic [NW-1:0]   bdata_r;

  logic [NW-1:0]   src_r, tgt_r;
  logic [ECW-1:0]  ecnt_r;
  logic            ovf_r;
  logic [NCW-1:0]  pcnt_r, rp_r;
  logic [NAW-1:0]  clr_r;
  logic [NW-1:0]   top_u_r;
  logic [ECW-1:0]  top_i_r;
  logic [NCW-1:0]  sp_r;
  logic [NW-1:0]   v_r;
  logic [NW-1:0]   node_r;
  logic [NCW-1:0]  len_r, k_r;
  logic [NW-1:0]   pnode_r;
  logic            last_r;
  logic            out_valid_r;
  dfs_pkg::out_item_t out_item_r;

  // edge decode
  logic [NW-1:0] ex, ey, v_cmb;
  logic          hit_x, hit_any;
  assign ex      = edata_r[NW-1:0];
  assign ey      = edata_r[2*NW-1:NW];
  assign hit_x   = (ex == top_u_r);
  assign hit_any = hit_x || (ey == top_u_r);
  assign v_cmb   = hit_x ? ey : ex;

  // parent table ports
  logic            par_we;
  logic [NAW-1:0]  par_waddr, par_raddr;
  logic [NW:0]     par_wdata;

  always_comb begin
    par_we    = 1'b0;
    par_waddr = clr_r;
    par_wdata = '0;
    if (ctrl.clr_step) begin
      par_we = 1'b1;
    end else if (ctrl.seed) begin
      par_we    = 1'b1;
      par_waddr = NAW'(src_r);
      par_wdata = {1'b1, {NW{1'b0}}};
    end else if (ctrl.push) begin
      par_we    = 1'b1;
      par_waddr = NAW'(v_r);
      par_wdata = {1'b1, top_u_r};
    end
  end

  always_comb begin
    if (ctrl.probe) begin
      par_raddr = NAW'(v_cmb);
    end else if (ctrl.tgt_rd) begin
      par_raddr = NAW'(tgt_r);
    end else begin
      par_raddr = NAW'(node_r);
    end
  end

  always_ff @(posedge clk) begin
    if (par_we) begin
      par_mem[par_waddr] <= par_wdata;
    end
    pdata_r <= par_mem[par_raddr];
  end

  // edge store
  logic edge_ok;
  assign edge_ok = (32'(in_a) < MAX_NODES) && (32'(in_b) < MAX_NODES);

  always_ff @(posedge clk) begin
    if (ctrl.add_edge && edge_ok && (32'(ecnt_r) < MAX_EDGES)) begin
      edge_mem[EAW'(ecnt_r)] <= {in_b, in_a};
    end
    edata_r <= edge_mem[EAW'(top_i_r)];
  end

  // search stack, holds the entries below the top
  logic [NCW-1:0] sp_m1, sp_m2;
  assign sp_m1 = sp_r - NCW'(1);
  assign sp_m2 = sp_r - NCW'(2);

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      stk_mem[NAW'(sp_m1)] <= {top_i_r + ECW'(1), top_u_r};
    end
    sdata_r <= stk_mem[NAW'(sp_m2)];
  end

  // path buffer
  logic [NCW-1:0] k_m1;
  assign k_m1 = k_r - NCW'(1);

  always_ff @(posedge clk) begin
    if (ctrl.wr_path) begin
      pbuf_mem[NAW'(k_m1)] <= node_r;
    end
    bdata_r <= pbuf_mem[NAW'(rp_r)];
  end

  // control and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r       <= NW'(1);
      tgt_r       <= NW'(1);
      ecnt_r      <= '0;
      ovf_r       <= 1'b0;
      pcnt_r      <= '0;
      rp_r        <= '0;
      clr_r       <= '0;
      sp_r        <= '0;
      top_i_r     <= '0;
      len_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (dfs_pkg::cfg_idx_e'(cfg_item.index))
          dfs_pkg::CFG_SOURCE: src_r <= cfg_item.wdata;
          dfs_pkg::CFG_TARGET: tgt_r <= cfg_item.wdata;
          default: ;
        endcase
      end
      if (ctrl.clear_graph) begin
        ecnt_r <= '0;
        ovf_r  <= 1'b0;
        pcnt_r <= '0;
        rp_r   <= '0;
      end
      if (ctrl.add_edge && edge_ok) begin
        if (32'(ecnt_r) < MAX_EDGES) begin
          ecnt_r <= ecnt_r + ECW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (ctrl.search_init) begin
        pcnt_r <= '0;
        rp_r   <= '0;
        clr_r  <= '0;
      end
      if (ctrl.clr_step) begin
        clr_r <= clr_r + NAW'(1);
      end
      if (ctrl.seed) begin
        top_i_r <= '0;
        sp_r    <= NCW'(1);
      end
      if (ctrl.next_edge) begin
        top_i_r <= top_i_r + ECW'(1);
      end
      if (ctrl.pop) begin
        sp_r <= sp_m1;
      end
      if (ctrl.load_top) begin
        top_i_r <= sdata_r[SW-1:NW];
      end
      if (ctrl.push) begin
        top_i_r <= '0;
        sp_r    <= sp_r + NCW'(1);
      end
      if (ctrl.trace_init) begin
        len_r <= NCW'(1);
      end
      if (ctrl.trace_step) begin
        len_r <= len_r + NCW'(1);
      end
      if (ctrl.wr_init) begin
        k_r <= len_r;
      end
      if (ctrl.wr_path) begin
        if (k_r == NCW'(1)) begin
          pcnt_r <= len_r;
        end else begin
          k_r <= k_m1;
        end
      end
      if (ctrl.rd_done && (rp_r < pcnt_r)) begin
        rp_r <= rp_r + NCW'(1);
      end
      if (ctrl.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctrl.add_edge || ctrl.search_init) begin
      pnode_r <= '0;
      last_r  <= 1'b0;
    end
    if (ctrl.rd_done) begin
      if (rp_r < pcnt_r) begin
        pnode_r <= bdata_r;
        last_r  <= ((rp_r + NCW'(1)) == pcnt_r);
      end else begin
        pnode_r <= '0;
        last_r  <= 1'b1;
      end
    end
    if (ctrl.seed) begin
      top_u_r <= src_r;
    end
    if (ctrl.load_top) begin
      top_u_r <= sdata_r[NW-1:0];
    end
    if (ctrl.push) begin
      top_u_r <= v_r;
    end
    if (ctrl.probe) begin
      v_r <= v_cmb;
    end
    if (ctrl.trace_init || ctrl.wr_init) begin
      node_r <= tgt_r;
    end
    if (ctrl.trace_step || ctrl.wr_step) begin
      node_r <= pdata_r[NW-1:0];
    end
    if (ctrl.load_out) begin
      out_item_r.found         <= (pcnt_r != '0);
      out_item_r.path_length   <= (32'(pcnt_r) > dfs_pkg::LEN_SAT) ?
                                  NW'(dfs_pkg::LEN_SAT) : NW'(pcnt_r);
      out_item_r.path_node     <= pnode_r;
      out_item_r.last_node     <= last_r;
      out_item_r.edge_overflow <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign stat.ends_ok   = (32'(src_r) < MAX_NODES) && (32'(tgt_r) < MAX_NODES);
  assign stat.clr_last  = (clr_r == NAW'(MAX_NODES - 1));
  assign stat.scan_more = (top_i_r < ecnt_r);
  assign stat.sp_one    = (sp_r == NCW'(1));
  assign stat.edge_hit  = hit_any && (32'(v_cmb) < MAX_NODES);
  assign stat.can_push  = !pdata_r[NW] && (32'(sp_r) < MAX_NODES);
  assign stat.pvisited  = pdata_r[NW];
  assign stat.trace_end = (node_r == src_r) || (32'(len_r) >= MAX_NODES);
  assign stat.k_one     = (k_r == NCW'(1));
  assign stat.out_busy  = out_valid_r;

endmodule

// File: src/dfs_path_finder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_path_finder_unit
// depth-first path search over an undirected edge list, with path readout
// ----------------------------------------------------------------------------
// one command is taken at a time. a clear returns no transaction; an add
// answers through the response state, and a read through the read wait
// and response states. a search first sweeps all MAX_NODES parent table
// entries clear, one entry a cycle, then walks the edge store through its
// single read port: every edge looked at from a stack top passes the scan
// and edge states, a parent lookup in the visit state follows when the
// edge touches the node, and each pop that leaves entries on the stack
// passes the pop wait state. the path is then traced twice through the
// parent table, a read and a step per path node each time. a new command
// is accepted only once the previous result has been taken.
// ----------------------------------------------------------------------------
module dfs_path_finder_unit #(
  parameter int MAX_NODES = dfs_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = dfs_pkg::DEF_MAX_EDGES
) (
  input  logic        clk,
  input  logic        rst_n,
  dfs_chan_if.sink    in_ch,
  dfs_chan_if.source  out_ch,
  dfs_chan_if.sink    cfg_ch
);

  dfs_pkg::ctrl_t  ctrl;
  dfs_pkg::stat_t  stat;
  dfs_pkg::state_t state;
  dfs_pkg::in_item_t in_item;
  dfs_pkg::cfg_item_t cfg_item;
  logic in_ready;

  assign in_item  = in_ch.data;
  assign cfg_item = cfg_ch.data;

  // configuration writes are always taken
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  dfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (dfs_pkg::cmd_e'(in_item.command)),
    .stat     (stat),
    .in_ready (in_ready),
    .ctrl     (ctrl),
    .state    (state)
  );

  dfs_dp #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_a      (in_item.edge_end_a),
    .in_b      (in_item.edge_end_b),
    .cfg_we    (cfg_ch.valid),
    .cfg_item  (cfg_item),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_item  (out_ch.data),
    .stat      (stat)
  );

  // never take a command while a result is still waiting
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_ch.valid)
    else $error("command accepted with result pending");

  // an add transaction is answered through the response state and the registered result valid
  a_add_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ready && (in_item.command == dfs_pkg::CMD_ADD))
      |-> ##2 out_ch.valid)
    else $error("add transaction without result");

  // stack push and pop are exclusive and only during the walk
  a_stack_ops: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.push || ctrl.pop) |->
      (!(ctrl.push && ctrl.pop) &&
       ((state == dfs_pkg::ST_SCAN) || (state == dfs_pkg::ST_VISIT))))
    else $error("stack operation outside the walk");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the depth-first path finder unit
// ----------------------------------------------------------------------------
// small graphs are built from random node pools, searched from configured
// source and target nodes, and read back node by node. an in-bench model of
// the edge scan, the explicit stack and the parent trace predicts every
// result transaction. both channel ends idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import dfs_pkg::*;

  localparam int NODES = DEF_MAX_NODES;
  localparam int EDGES = DEF_MAX_EDGES;

  // ---------------------------------------------------------------------------
  // scoreboard: path finder model plus queue of expected results
  // ---------------------------------------------------------------------------
  class path_scoreboard;
    bit [NODE_W-1:0] src_node, tgt_node;
    bit [19:0]       edge_mem [EDGES];
    int              edge_count;
    bit [10:0]       parent [NODES];
    int              stk_node [NODES];
    int              stk_next [NODES];
    bit [NODE_W-1:0] path_buf [NODES];
    int              path_count, rd_ptr;
    bit              overflow;
    out_item_t       pending [$];
    int              errors, checked, searches, founds, overflow_seen;

    function void set_cfg(cfg_idx_e idx, bit [NODE_W-1:0] val);
      if (idx == CFG_SOURCE) src_node = val;
      else tgt_node = val;
    endfunction

    // depth-first walk, neighbours taken in edge insertion order
    function void walk_graph();
      int sp, u, i, v, len, node;
      bit pushed;
      path_count = 0;
      rd_ptr     = 0;
      searches++;
      for (int n = 0; n < NODES; n++) parent[n] = '0;
      parent[src_node] = 11'h400;
      stk_node[0] = src_node;
      stk_next[0] = 0;
      sp = 1;
      while (sp > 0) begin
        u = stk_node[sp-1];
        pushed = 0;
        for (i = stk_next[sp-1]; i < edge_count; i++) begin
          if (edge_mem[i][9:0] == u) v = edge_mem[i][19:10];
          else if (edge_mem[i][19:10] == u) v = edge_mem[i][9:0];
          else continue;
          if (!parent[v][10] && sp < NODES) begin
            parent[v] = {1'b1, u[9:0]};
            stk_next[sp-1] = i + 1;
            stk_node[sp] = v;
            stk_next[sp] = 0;
            sp++;
            pushed = 1;
            break;
          end
        end
        if (!pushed) sp--;
      end
      if (!parent[tgt_node][10]) return;
      len  = 1;
      node = tgt_node;
      while (node != src_node && len < NODES) begin
        node = parent[node][9:0];
        len++;
      end
      node = tgt_node;
      for (int k = len; k > 0; k--) begin
        path_buf[k-1] = NODE_W'(node);
        node = parent[node][9:0];
      end
      path_count = len;
      founds++;
    endfunction

    function void note_command(in_item_t it);
      out_item_t r;
      r = '0;
      case (cmd_e'(it.command))
        CMD_CLEAR: begin
          edge_count = 0;
          overflow   = 0;
          path_count = 0;
          rd_ptr     = 0;
          return;
        end
        CMD_ADD: begin
          if (edge_count < EDGES) begin
            edge_mem[edge_count] = {it.edge_end_b, it.edge_end_a};
            edge_count++;
          end else begin
            overflow = 1;
          end
        end
        CMD_SEARCH: walk_graph();
        default: begin
          if (rd_ptr < path_count) begin
            r.path_node = path_buf[rd_ptr];
            rd_ptr++;
            r.last_node = (rd_ptr == path_count);
          end else begin
            r.last_node = 1'b1;
          end
        end
      endcase
      r.found         = path_count > 0;
      r.path_length   = NODE_W'(path_count > LEN_SAT ? LEN_SAT : path_count);
      r.edge_overflow = overflow;
      if (overflow) overflow_seen++;
      pending = {pending, r};
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result transaction %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.found != want.found) begin
        $display("%0t: found exp %0d got %0d", $time, want.found, got.found);
        errors++;
      end
      if (got.path_length != want.path_length) begin
        $display("%0t: path_length exp %0d got %0d", $time, want.path_length,
                 got.path_length);
        errors++;
      end
      if (got.path_node != want.path_node) begin
        $display("%0t: path_node exp %0d got %0d", $time, want.path_node,
                 got.path_node);
        errors++;
      end
      if (got.last_node != want.last_node) begin
        $display("%0t: last_node exp %0d got %0d", $time, want.last_node,
                 got.last_node);
        errors++;
      end
      if (got.edge_overflow != want.edge_overflow) begin
        $display("%0t: edge_overflow exp %0d got %0d", $time, want.edge_overflow,
                 got.edge_overflow);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  dfs_chan_if #(.T(in_item_t))  in_ch ();
  dfs_chan_if #(.T(out_item_t)) out_ch ();
  dfs_chan_if #(.T(cfg_item_t)) cfg_ch ();

  dfs_path_finder_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  path_scoreboard sb;

  // sender burst shaping
  int burst_left;
  int sent_items;

  // receiver stall pattern
  int stall_mode;
  int stall_cnt;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: mode is redrawn from the stall counter, mode 0 never stalls
  always @(negedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
      2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
      default: out_ch.ready <= (stall_cnt % 8 < 5);
    endcase
  end

  // result monitor, sampled on the rising edge
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  // one command transaction; valid stays high into the next item of a burst
  task automatic send_cmd(cmd_e cmd, bit [NODE_W-1:0] a, bit [NODE_W-1:0] b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk);
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid           = 1'b1;
    in_ch.data.command    = cmd;
    in_ch.data.edge_end_a = a;
    in_ch.data.edge_end_b = b;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    sb.note_command(in_ch.data);
    sent_items++;
  endtask

  // wait until every expected result has come, then let a clear settle
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_cfg(cfg_idx_e idx, bit [NODE_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid      = 1'b1;
    cfg_ch.data.index = idx;
    cfg_ch.data.wdata = val;
    forever begin
      @(posedge clk);
      if (cfg_ch.ready) break;
    end
    sb.set_cfg(idx, val);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_ends(bit [NODE_W-1:0] s, bit [NODE_W-1:0] t);
    drain();
    write_cfg(CFG_SOURCE, s);
    write_cfg(CFG_TARGET, t);
  endtask

  function automatic bit [NODE_W-1:0] rand_node();
    return NODE_W'($urandom_range(1, 1023));
  endfunction

  task automatic read_path(int n);
    repeat (n) send_cmd(CMD_READ, rand_node(), rand_node());
  endtask

  // random graph phase over a small node pool
  task automatic graph_phase();
    bit [NODE_W-1:0] pool [$];
    int npool, nedge, nread;
    bit [NODE_W-1:0] s, t;
    npool = $urandom_range(3, 12);
    repeat (npool) pool = {pool, rand_node()};
    if ($urandom_range(0, 3) == 0) pool = {pool, 10'd1023};
    if ($urandom_range(0, 3) == 0) pool = {pool, 10'd1};
    if (sb.edge_count > 30 || $urandom_range(0, 2) != 0)
      send_cmd(CMD_CLEAR, rand_node(), rand_node());
    nedge = $urandom_range(2, 16);
    repeat (nedge) begin
      if ($urandom_range(0, 9) == 0) begin
        s = pool[$urandom_range(0, pool.size() - 1)];
        send_cmd(CMD_ADD, s, s);
      end else begin
        send_cmd(CMD_ADD, pool[$urandom_range(0, pool.size() - 1)],
                 pool[$urandom_range(0, pool.size() - 1)]);
      end
    end
    s = pool[$urandom_range(0, pool.size() - 1)];
    case ($urandom_range(0, 5))
      0:       t = s;
      1:       t = rand_node();
      default: t = pool[$urandom_range(0, pool.size() - 1)];
    endcase
    set_ends(s, t);
    send_cmd(CMD_SEARCH, rand_node(), rand_node());
    nread = sb.path_count + $urandom_range(0, 2);
    if (nread > 16) nread = 16;
    if ($urandom_range(0, 4) == 0) begin
      // noise: add and search in the middle of a readout
      read_path(nread / 2);
      send_cmd(CMD_ADD, pool[0], rand_node());
      read_path(1);
      send_cmd(CMD_SEARCH, rand_node(), rand_node());
    end
    read_path(nread);
  endtask

  initial begin
    int random_start;
    sb           = new();
    sb.src_node  = 1;
    sb.tgt_node  = 1;
    burst_left   = 0;
    sent_items   = 0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // read before any search, then source equals target with an empty graph
    read_path(1);
    send_cmd(CMD_SEARCH, 10'd1023, 10'd1);
    read_path(2);
    // extremes of the endpoints, self-loops
    send_cmd(CMD_ADD, 10'd1, 10'd1023);
    send_cmd(CMD_ADD, 10'd1023, 10'd1023);
    send_cmd(CMD_ADD, 10'd1, 10'd1);
    send_cmd(CMD_ADD, 10'd1023, 10'd682);
    send_cmd(CMD_ADD, 10'd341, 10'd682);
    set_ends(10'd1, 10'd341);
    send_cmd(CMD_SEARCH, 10'd0, 10'd0);
    read_path(5);
    set_ends(10'd1023, 10'd1023);
    send_cmd(CMD_SEARCH, 10'd0, 10'd0);
    read_path(2);
    // clear drops the path; search after a clear finds nothing
    send_cmd(CMD_CLEAR, 10'd0, 10'd0);
    read_path(1);
    set_ends(10'd1, 10'd1023);
    send_cmd(CMD_SEARCH, 10'd0, 10'd0);
    read_path(1);
    send_cmd(CMD_CLEAR, 10'd0, 10'd0);
    send_cmd(CMD_ADD, 10'd5, 10'd6);

    // random graphs; each phase pauses for the block to drain before the
    // configuration write
    random_start = sent_items;
    while (sent_items - random_start < 116) graph_phase();

    drain();
    repeat (50) @(posedge clk);
    $display("covered %0d commands, %0d results, %0d searches (%0d with a path)",
             sent_items, sb.checked, sb.searches, sb.founds);
    $display("edge store overflow reported on %0d results", sb.overflow_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
